// ===== sv/rdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rdq_pkg
// Types, codes and sizes shared by the reversible deque engine.
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    localparam int CMD_W     = 3;
    localparam int ELEMENT_W = 16;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EMIT    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_ELEMENT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [ELEMENT_W-1:0] value;
    } in_req_t;

    typedef struct packed {
        logic [ELEMENT_W-1:0] element;
        logic [STATUS_W-1:0]  status;
        logic                 last;
    } out_req_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHIFT,
        OP_ROT_L,
        OP_ROT_R
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [CNT_BITS-1:0]   count;
        logic [VALUE_BITS-1:0] value;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

endpackage

// ===== sv/reversible_deque_engine.sv =====
// ----------------------------------------------------------------------------
// reversible_deque_engine
// Bounded deque with direction flag and sticky error, held in a row of cells.
// ----------------------------------------------------------------------------
// Requests arrive on s_valid/s_ready/s_data (command and value); results
// leave on m_valid/m_ready/m_data (element, status, last).
// Clear, load, reverse and delete update the cells and counters and give no
// result; the next request is taken in the following cycle.
// Emit with the error flag set, or on an empty deque, gives one status result
// from the output register in the cycle after the request.
// Emit on a filled deque streams N elements at one per cycle while the
// receiver accepts, N being the element count: the cell row rotates by one
// slot per result and is back in place after the last one; no request is
// taken during the stream.
// A stalled receiver holds the output register and pauses the rotation.
// Non-emit requests are taken while a result waits; an emit waits for room.
// Reset empties the deque and clears both flags; cell contents are kept.
// ----------------------------------------------------------------------------
module reversible_deque_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rdq_pkg::in_req_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rdq_pkg::out_req_t m_data
);

    rdq_pkg::state_t              state_reg, state_next;
    logic [rdq_pkg::CNT_BITS-1:0] count_reg, count_next;
    logic [rdq_pkg::CNT_BITS-1:0] remain_reg, remain_next;
    logic                         rev_reg, rev_next;
    logic                         err_reg, err_next;
    logic                         out_valid_reg, out_valid_next;
    rdq_pkg::out_req_t            out_reg, out_next;

    rdq_pkg::cell_ctrl_t            ctrl;
    logic [rdq_pkg::VALUE_BITS-1:0] head_data;
    logic [rdq_pkg::VALUE_BITS-1:0] tail_data;
    logic [rdq_pkg::VALUE_BITS-1:0] tap_data;
    logic                           out_free;
    logic                           accept;
    logic                           is_emit;

    assign out_free = !out_valid_reg || m_ready;
    assign is_emit  = (s_data.command == rdq_pkg::CMD_EMIT);
    assign s_ready  = (state_reg == rdq_pkg::S_IDLE) && (!is_emit || out_free);
    assign accept   = s_valid && s_ready;
    assign tap_data = rev_reg ? tail_data : head_data;

    rdq_chain u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .head_data (head_data),
        .tail_data (tail_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rdq_pkg::S_IDLE: begin
                if (accept && is_emit && !err_reg && (count_reg != '0)) begin
                    state_next = rdq_pkg::S_EMIT;
                end
            end
            rdq_pkg::S_EMIT: begin
                if (out_free && (remain_reg == rdq_pkg::CNT_BITS'(1))) begin
                    state_next = rdq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rdq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next     = count_reg;
        remain_next    = remain_reg;
        rev_next       = rev_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        ctrl.op        = rdq_pkg::OP_HOLD;
        ctrl.count     = count_reg;
        ctrl.value     = rdq_pkg::VALUE_BITS'(s_data.value);

        unique case (state_reg)
            rdq_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (s_data.command)
                        rdq_pkg::CMD_CLEAR: begin
                            count_next = '0;
                            rev_next   = 1'b0;
                            err_next   = 1'b0;
                        end
                        rdq_pkg::CMD_LOAD: begin
                            if (count_reg != rdq_pkg::CNT_BITS'(rdq_pkg::DEPTH)) begin
                                ctrl.op    = rdq_pkg::OP_LOAD;
                                count_next = count_reg + rdq_pkg::CNT_BITS'(1);
                            end
                        end
                        rdq_pkg::CMD_REVERSE: begin
                            if (!err_reg) begin
                                rev_next = !rev_reg;
                            end
                        end
                        rdq_pkg::CMD_DELETE: begin
                            if (!err_reg) begin
                                if (count_reg == '0) begin
                                    err_next = 1'b1;
                                end else begin
                                    if (!rev_reg) begin
                                        ctrl.op = rdq_pkg::OP_SHIFT;
                                    end
                                    count_next = count_reg - rdq_pkg::CNT_BITS'(1);
                                end
                            end
                        end
                        rdq_pkg::CMD_EMIT: begin
                            if (err_reg) begin
                                out_valid_next   = 1'b1;
                                out_next.element = '0;
                                out_next.status  = rdq_pkg::ST_ERROR;
                                out_next.last    = 1'b1;
                            end else if (count_reg == '0) begin
                                out_valid_next   = 1'b1;
                                out_next.element = '0;
                                out_next.status  = rdq_pkg::ST_EMPTY;
                                out_next.last    = 1'b1;
                            end else begin
                                remain_next = count_reg;
                            end
                        end
                        default: begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            rdq_pkg::S_EMIT: begin
                if (out_free) begin
                    ctrl.op          = rev_reg ? rdq_pkg::OP_ROT_R : rdq_pkg::OP_ROT_L;
                    out_valid_next   = 1'b1;
                    out_next.element = rdq_pkg::ELEMENT_W'(tap_data);
                    out_next.status  = rdq_pkg::ST_ELEMENT;
                    out_next.last    = (remain_reg == rdq_pkg::CNT_BITS'(1));
                    remain_next      = remain_reg - rdq_pkg::CNT_BITS'(1);
                end
            end
            default: begin
                ctrl.op = rdq_pkg::OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rdq_pkg::S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            rev_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            rev_reg       <= rev_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sv/rdq_cell.sv =====
// ----------------------------------------------------------------------------
// rdq_cell
// One deque slot: loads, shifts toward the front, or rotates within the
// occupied region by taking data from a neighbor or from the wrap bus.
// ----------------------------------------------------------------------------
module rdq_cell (
    input  logic                              aclk,
    input  rdq_pkg::cell_ctrl_t               ctrl,
    input  logic [rdq_pkg::IDX_BITS-1:0]      idx,
    input  logic [rdq_pkg::VALUE_BITS-1:0]    left_data,
    input  logic [rdq_pkg::VALUE_BITS-1:0]    right_data,
    input  logic [rdq_pkg::VALUE_BITS-1:0]    wrap_data,
    output logic [rdq_pkg::VALUE_BITS-1:0]    data,
    output logic [rdq_pkg::VALUE_BITS-1:0]    tail_tap
);

    logic [rdq_pkg::VALUE_BITS-1:0] data_reg;
    logic [rdq_pkg::VALUE_BITS-1:0] data_next;
    logic [rdq_pkg::CNT_BITS-1:0]   pos;
    logic                           is_tail;
    logic                           is_head;
    logic                           in_region;

    assign pos       = rdq_pkg::CNT_BITS'(idx);
    assign is_tail   = (pos == (ctrl.count - rdq_pkg::CNT_BITS'(1))) && (ctrl.count != '0);
    assign is_head   = (pos == '0);
    assign in_region = (pos < ctrl.count);

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            rdq_pkg::OP_LOAD: begin
                if (pos == ctrl.count) begin
                    data_next = ctrl.value;
                end
            end
            rdq_pkg::OP_SHIFT: begin
                data_next = right_data;
            end
            rdq_pkg::OP_ROT_L: begin
                if (is_tail) begin
                    data_next = wrap_data;
                end else if (in_region) begin
                    data_next = right_data;
                end
            end
            rdq_pkg::OP_ROT_R: begin
                if (is_head) begin
                    data_next = wrap_data;
                end else if (in_region) begin
                    data_next = left_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign tail_tap = is_tail ? data_reg : '0;

endmodule

// ===== sv/rdq_chain.sv =====
// ----------------------------------------------------------------------------
// rdq_chain
// Row of deque cells with neighbor links, front tap and tail bus.
// ----------------------------------------------------------------------------
module rdq_chain (
    input  logic                              aclk,
    input  rdq_pkg::cell_ctrl_t               ctrl,
    output logic [rdq_pkg::VALUE_BITS-1:0]    head_data,
    output logic [rdq_pkg::VALUE_BITS-1:0]    tail_data
);

    logic [rdq_pkg::VALUE_BITS-1:0] cell_data [rdq_pkg::DEPTH];
    logic [rdq_pkg::VALUE_BITS-1:0] cell_tap  [rdq_pkg::DEPTH];
    logic [rdq_pkg::VALUE_BITS-1:0] wrap_bus;

    // rotate left feeds the old front into the tail, rotate right the tail into the front
    assign wrap_bus = (ctrl.op == rdq_pkg::OP_ROT_R) ? tail_data : head_data;

    for (genvar i = 0; i < rdq_pkg::DEPTH; i++) begin : g_cell
        logic [rdq_pkg::VALUE_BITS-1:0] left_data;
        logic [rdq_pkg::VALUE_BITS-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = cell_data[i];
        end else begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == rdq_pkg::DEPTH - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        rdq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .idx        (rdq_pkg::IDX_BITS'(i)),
            .left_data  (left_data),
            .right_data (right_data),
            .wrap_data  (wrap_bus),
            .data       (cell_data[i]),
            .tail_tap   (cell_tap[i])
        );
    end

    always_comb begin
        tail_data = '0;
        for (int k = 0; k < rdq_pkg::DEPTH; k++) begin
            tail_data = tail_data | cell_tap[k];
        end
    end

    assign head_data = cell_data[0];

endmodule
